[hdl/kvt_pkg.sv]
`default_nettype none

package kvt_pkg;

   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;

   localparam int ACTION_BITS    = 2;
   localparam int COUNT_OUT_BITS = 5;
   localparam int CNT_BITS       = $clog2(ENTRIES + 1);
   localparam int IDX_BITS       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ENTRY_BITS     = KEY_BITS + VALUE_BITS;

   // request beat: action, key, value from bit 0 up
   localparam int REQ_FIELD_BITS = ACTION_BITS + KEY_BITS + VALUE_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int REQ_KEY_LSB    = ACTION_BITS;
   localparam int REQ_VALUE_LSB  = ACTION_BITS + KEY_BITS;

   // response beat: found, value_out, table_full, entry_count from bit 0 up
   localparam int RSP_FIELD_BITS = 1 + VALUE_BITS + 1 + COUNT_OUT_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_VALUE_LSB  = 1;
   localparam int RSP_FULL_BIT   = 1 + VALUE_BITS;
   localparam int RSP_COUNT_LSB  = 2 + VALUE_BITS;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_DEFINE = 2'd0,
      ACT_LOOKUP = 2'd1,
      ACT_ERASE  = 2'd2,
      ACT_PROBE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_SHIFT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic start;      // latch request beat, clear flags and walk pointer
      logic step;       // advance the read walk one entry
      logic hit_load;   // record the hit, point the walk past it
      logic write_upd;  // write key/value at hit slot or append at count
      logic shift_wr;   // write back the entry read last cycle one place lower
      logic count_dec;  // drop one entry
      logic set_full;   // flag a refused define
      logic rsp_load;   // load the response register
   } kvt_cmd_type;

   typedef struct packed {
      action_type action;
      logic       hit;        // compared entry matches the key
      logic       walk_done;  // no read pending and none left to issue
      logic       full;       // table holds ENTRIES entries
      logic       rsp_free;   // response register can take a beat
   } kvt_stat_type;

   function automatic logic [COUNT_OUT_BITS-1:0] count_out(input logic [CNT_BITS-1:0] c);
      logic [CNT_BITS+COUNT_OUT_BITS-1:0] wide;
      wide = {{COUNT_OUT_BITS{1'b0}}, c};
      return wide[COUNT_OUT_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

[hdl/kvt_ram.sv]
`default_nettype none

module kvt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[hdl/kvt_ctrl.sv]
`default_nettype none

module kvt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_ready,
   input  wire kvt_pkg::kvt_stat_type stat,
   output kvt_pkg::kvt_cmd_type       cmd
);
   import kvt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.hit) begin
               case (stat.action)
                  ACT_DEFINE: state_in = ST_UPDATE;
                  ACT_ERASE:  state_in = ST_SHIFT;
                  default:    state_in = ST_RESP;
               endcase
            end else if (stat.walk_done) begin
               if (stat.action == ACT_DEFINE && !stat.full) begin
                  state_in = ST_UPDATE;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_UPDATE: state_in = ST_RESP;
         ST_SHIFT: begin
            if (stat.walk_done) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_tvalid;
         end
         ST_SCAN: begin
            if (stat.hit) begin
               cmd.hit_load = 1'b1;
            end else begin
               cmd.step     = 1'b1;
               cmd.set_full = stat.walk_done && stat.action == ACT_DEFINE && stat.full;
            end
         end
         ST_UPDATE: cmd.write_upd = 1'b1;
         ST_SHIFT: begin
            cmd.step      = 1'b1;
            cmd.shift_wr  = 1'b1;
            cmd.count_dec = stat.walk_done;
         end
         ST_RESP: cmd.rsp_load = stat.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

[hdl/kvt_dp.sv]
`default_nettype none

module kvt_dp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [kvt_pkg::REQ_TDATA_BITS-1:0]    req_tdata,
   input  wire kvt_pkg::kvt_cmd_type                  cmd,
   output kvt_pkg::kvt_stat_type                      stat,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic      [kvt_pkg::RSP_TDATA_BITS-1:0]    rsp_tdata
);
   import kvt_pkg::*;

   action_type              action_ff, action_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [VALUE_BITS-1:0]   val_ff, val_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [CNT_BITS-1:0]     issue_ff, issue_in;
   logic [IDX_BITS-1:0]     cmp_idx_ff, cmp_idx_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic [IDX_BITS-1:0]     slot_ff, slot_in;
   logic                    found_ff, found_in;
   logic                    full_ff, full_in;
   logic [VALUE_BITS-1:0]   vout_ff, vout_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   logic [RSP_TDATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                    more;
   logic                    ram_we;
   logic [IDX_BITS-1:0]     ram_waddr;
   logic [ENTRY_BITS-1:0]   ram_wdata;
   logic [ENTRY_BITS-1:0]   ram_rdata;
   logic [KEY_BITS-1:0]     rd_key;
   logic [VALUE_BITS-1:0]   rd_val;

   assign more   = issue_ff < count_ff;
   assign rd_key = ram_rdata[ENTRY_BITS-1:VALUE_BITS];
   assign rd_val = ram_rdata[VALUE_BITS-1:0];

   kvt_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (issue_ff[IDX_BITS-1:0]),
      .rd_data (ram_rdata)
   );

   // shift writes the entry read last cycle one place down; update writes the request pair
   always_comb begin
      if (cmd.shift_wr) begin
         ram_we    = cmp_vld_ff;
         ram_waddr = cmp_idx_ff - IDX_BITS'(1);
         ram_wdata = ram_rdata;
      end else begin
         ram_we    = cmd.write_upd;
         ram_waddr = found_ff ? slot_ff : count_ff[IDX_BITS-1:0];
         ram_wdata = {key_ff, val_ff};
      end
   end

   always_comb begin
      stat.action    = action_ff;
      stat.hit       = cmp_vld_ff && (rd_key == key_ff);
      stat.walk_done = !cmp_vld_ff && !more;
      stat.full      = count_ff == CNT_BITS'(ENTRIES);
      stat.rsp_free  = !rsp_vld_ff || rsp_tready;
   end

   always_comb begin
      action_in   = action_ff;
      key_in      = key_ff;
      val_in      = val_ff;
      count_in    = count_ff;
      issue_in    = issue_ff;
      cmp_idx_in  = cmp_idx_ff;
      cmp_vld_in  = cmp_vld_ff;
      slot_in     = slot_ff;
      found_in    = found_ff;
      full_in     = full_ff;
      vout_in     = vout_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;

      if (cmd.start) begin
         action_in  = action_type'(req_tdata[ACTION_BITS-1:0]);
         key_in     = req_tdata[REQ_KEY_LSB +: KEY_BITS];
         val_in     = req_tdata[REQ_VALUE_LSB +: VALUE_BITS];
         issue_in   = '0;
         cmp_vld_in = 1'b0;
         found_in   = 1'b0;
         full_in    = 1'b0;
         vout_in    = '0;
      end

      if (cmd.step) begin
         cmp_vld_in = more;
         cmp_idx_in = issue_ff[IDX_BITS-1:0];
         if (more) issue_in = issue_ff + CNT_BITS'(1);
      end

      if (cmd.hit_load) begin
         found_in   = 1'b1;
         slot_in    = cmp_idx_ff;
         issue_in   = CNT_BITS'(cmp_idx_ff) + CNT_BITS'(1);
         cmp_vld_in = 1'b0;
         if (action_ff == ACT_LOOKUP) vout_in = rd_val;
      end

      if (cmd.set_full) full_in = 1'b1;

      if (cmd.write_upd && !found_ff) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CNT_BITS'(1);
      end

      // hold the beat until taken
      if (cmd.rsp_load) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = '0;
         rsp_data_in[0]                            = found_ff;
         rsp_data_in[RSP_VALUE_LSB +: VALUE_BITS]  = vout_ff;
         rsp_data_in[RSP_FULL_BIT]                 = full_ff;
         rsp_data_in[RSP_COUNT_LSB +: COUNT_OUT_BITS] = count_out(count_ff);
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      issue_ff    <= issue_in;
      cmp_idx_ff  <= cmp_idx_in;
      slot_ff     <= slot_in;
      found_ff    <= found_in;
      full_ff     <= full_in;
      vout_ff     <= vout_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[hdl/key_value_table_unit.sv]
`default_nettype none

// Channel   Dir   Ports                       Beat contents
// req       in    req_tvalid/tready/tdata     action, key, value
// rsp       out   rsp_tvalid/tready/tdata     found, value_out, table_full, entry_count
//
// One request at a time. Each request is accepted in the idle state, then the key/value RAM
// is scanned (one registered read per cycle) until a hit or past the last entry; on an empty
// table nothing is read. A storing define then writes the pair; an erase shifts the entries
// above the hit one place down; then the response is loaded. The longest request is an erase
// of the first of 16 entries. The response state stalls while the
// output register still holds an untaken beat; that beat waits there while the next request
// is taken. Reset empties the table at once; no clearing pass.

module key_value_table_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // action[1:0], key[33:2], value[65:34], zero fill
   input  wire logic [kvt_pkg::REQ_TDATA_BITS-1:0]  req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // found[0], value_out[32:1], table_full[33], entry_count[38:34], zero fill
   output logic      [kvt_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata
);
   import kvt_pkg::*;

   kvt_cmd_type  cmd;
   kvt_stat_type stat;

   kvt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_ready  (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   kvt_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
